// ----- hw/rtl/kexp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kexp_pkg
// Types and codes shared by the key-exchange-init message parser.
// ----------------------------------------------------------------------------
package kexp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_COOKIE = 3'd1,
    PH_LEN    = 3'd2,
    PH_LIST   = 3'd3,
    PH_BOOL   = 3'd4,
    PH_RESV   = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  // Byte class codes
  localparam logic [2:0] CLS_TYPE    = 3'd0;
  localparam logic [2:0] CLS_COOKIE  = 3'd1;
  localparam logic [2:0] CLS_LEN     = 3'd2;
  localparam logic [2:0] CLS_LIST    = 3'd3;
  localparam logic [2:0] CLS_BOOL    = 3'd4;
  localparam logic [2:0] CLS_RESV    = 3'd5;
  localparam logic [2:0] CLS_IGNORED = 3'd6;

  // Status codes
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_BAD_TYPE      = 4'd1;
  localparam logic [3:0] ST_TRUNC_COOKIE  = 4'd2;
  localparam logic [3:0] ST_TRUNC_LEN     = 4'd3;
  localparam logic [3:0] ST_TRUNC_LIST    = 4'd4;
  localparam logic [3:0] ST_TRUNC_BOOL    = 4'd5;
  localparam logic [3:0] ST_TRUNC_RESV    = 4'd6;
  localparam logic [3:0] ST_RESV_NONZERO  = 4'd7;
  localparam logic [3:0] ST_EXTRA_BYTES   = 4'd8;

  localparam logic [7:0] EXPECTED_TYPE_RST = 8'd20;
  localparam logic [2:0] LEN_BYTES         = 3'd4;
  localparam logic [2:0] RESV_BYTES        = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } kexp_in_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [3:0] list_index;
    logic [7:0] byte_out;
    logic [3:0] status;
    logic       done_res;
    logic       first_follows;
  } kexp_out_t;

endpackage : kexp_pkg
`default_nettype wire

// ----- hw/rtl/kexinit_message_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kexinit_message_parser
// Byte-wide streaming parser for a key-exchange-init payload.
// ----------------------------------------------------------------------------
// Feed the payload one byte per beat, with last set on its final byte. Each
// input beat yields exactly one output beat carrying the byte, its field class
// (type, cookie, length, list, boolean, reserved, ignored) and its name-list
// index. The first error is latched and later bytes come out as ignored; the
// status on the beat marked last is final, and the parser then re-arms for the
// next payload. Unless a stalled output holds off the input, the block takes
// one byte per cycle: the whole state update is a single level of small logic
// (a 32-bit length shift, a 32-bit decrement and zero test) between the parse
// registers and one output register. cfg_wdata sets the expected message type
// and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module kexinit_message_parser
  import kexp_pkg::*;
#(
  parameter int COOKIE_LEN = 16,  // 1..32
  parameter int NUM_LISTS  = 10   // 1..15
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input beats
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire kexp_in_t  in_data,
  // output beats
  output logic           out_valid,
  input  wire logic      out_stall,
  output kexp_out_t      out_data,
  // configuration
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  phase_t      phase_r,   phase_nxt;
  logic [4:0]  count_r,   count_nxt;    // cookie / length / reserved byte count
  logic [3:0]  list_r,    list_nxt;     // current name list
  logic [31:0] shift_r,   shift_nxt;    // length being assembled, big-endian
  logic [31:0] remain_r,  remain_nxt;   // list bytes still to come
  logic [7:0]  resv_or_r, resv_or_nxt;  // OR of reserved bytes seen
  logic [3:0]  err_r,     err_nxt;      // latched error, ST_OK if none
  logic        follows_r, follows_nxt;  // parsed boolean
  logic [7:0]  exp_type_r;

  logic        out_valid_r;
  kexp_out_t   out_data_r;

  logic        in_acc;
  logic [7:0]  b;
  logic [5:0]  count_inc;     // one wider so a 32-byte cookie is reachable
  logic [31:0] shift_new;
  logic [31:0] remain_dec;
  logic [3:0]  list_inc;
  phase_t      after_list;    // phase following the end of a name list

  logic [2:0]  cls;
  logic [3:0]  idx;
  logic [3:0]  status;

  // An output beat waiting on a stalled receiver holds off the input.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_data.data_byte;

  assign count_inc  = {1'b0, count_r} + 6'd1;
  assign shift_new  = {shift_r[23:0], b};
  assign remain_dec = remain_r - 32'd1;
  assign list_inc   = list_r + 4'd1;
  assign after_list = (list_inc >= 4'(NUM_LISTS)) ? PH_BOOL : PH_LEN;

  // --------------------------------------------------------------------------
  // Next parse state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    list_nxt    = list_r;
    shift_nxt   = shift_r;
    remain_nxt  = remain_r;
    resv_or_nxt = resv_or_r;
    err_nxt     = err_r;
    follows_nxt = follows_r;

    // Once an error is latched the rest of the payload is ignored.
    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_TYPE: begin
          if (b != exp_type_r) begin
            err_nxt = ST_BAD_TYPE;
          end else begin
            count_nxt = '0;
            phase_nxt = PH_COOKIE;
          end
        end
        PH_COOKIE: begin
          count_nxt = count_inc[4:0];
          if (count_inc >= 6'(COOKIE_LEN)) begin
            list_nxt  = '0;
            count_nxt = '0;
            shift_nxt = '0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          shift_nxt = shift_new;
          count_nxt = count_inc[4:0];
          if (count_inc >= 6'(LEN_BYTES)) begin
            count_nxt  = '0;
            remain_nxt = shift_new;
            if (shift_new == '0) begin
              // empty list: straight on to the next one
              list_nxt  = list_inc;
              shift_nxt = '0;
              phase_nxt = after_list;
            end else begin
              phase_nxt = PH_LIST;
            end
          end
        end
        PH_LIST: begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            list_nxt  = list_inc;
            count_nxt = '0;
            shift_nxt = '0;
            phase_nxt = after_list;
          end
        end
        PH_BOOL: begin
          follows_nxt = (b != 8'd0);
          count_nxt   = '0;
          resv_or_nxt = '0;
          phase_nxt   = PH_RESV;
        end
        PH_RESV: begin
          resv_or_nxt = resv_or_r | b;
          count_nxt   = count_inc[4:0];
          if (count_inc >= 6'(RESV_BYTES)) begin
            count_nxt = '0;
            if ((resv_or_r | b) != 8'd0) begin
              err_nxt = ST_RESV_NONZERO;
            end else begin
              phase_nxt = PH_END;
            end
          end
        end
        PH_END: begin
          err_nxt = ST_EXTRA_BYTES;
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output beat contents
  // --------------------------------------------------------------------------
  always_comb begin
    cls = CLS_IGNORED;
    idx = '0;
    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_TYPE:   cls = CLS_TYPE;
        PH_COOKIE: cls = CLS_COOKIE;
        PH_LEN: begin
          cls = CLS_LEN;
          idx = list_r;
        end
        PH_LIST: begin
          cls = CLS_LIST;
          idx = list_r;
        end
        PH_BOOL:   cls = CLS_BOOL;
        PH_RESV:   cls = CLS_RESV;
        PH_END:    cls = CLS_IGNORED;
        default:   cls = CLS_TYPE;
      endcase
    end

    // Truncation is only judged on the final byte, from the updated phase.
    status = err_nxt;
    if (in_data.last && (err_nxt == ST_OK)) begin
      unique case (phase_nxt)
        PH_COOKIE: status = ST_TRUNC_COOKIE;
        PH_LEN:    status = ST_TRUNC_LEN;
        PH_LIST:   status = ST_TRUNC_LIST;
        PH_BOOL:   status = ST_TRUNC_BOOL;
        PH_RESV:   status = ST_TRUNC_RESV;
        PH_END:    status = ST_OK;
        default:   status = ST_TRUNC_COOKIE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      count_r     <= '0;
      list_r      <= '0;
      shift_r     <= '0;
      remain_r    <= '0;
      resv_or_r   <= '0;
      err_r       <= ST_OK;
      follows_r   <= 1'b0;
      exp_type_r  <= EXPECTED_TYPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        exp_type_r <= cfg_wdata;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
        if (in_data.last) begin
          // end of payload: re-arm
          phase_r   <= PH_TYPE;
          count_r   <= '0;
          list_r    <= '0;
          shift_r   <= '0;
          remain_r  <= '0;
          resv_or_r <= '0;
          err_r     <= ST_OK;
          follows_r <= 1'b0;
        end else begin
          phase_r   <= phase_nxt;
          count_r   <= count_nxt;
          list_r    <= list_nxt;
          shift_r   <= shift_nxt;
          remain_r  <= remain_nxt;
          resv_or_r <= resv_or_nxt;
          err_r     <= err_nxt;
          follows_r <= follows_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.byte_class    <= cls;
      out_data_r.list_index    <= idx;
      out_data_r.byte_out      <= b;
      out_data_r.status        <= status;
      out_data_r.done_res      <= in_data.last;
      out_data_r.first_follows <= follows_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A final beat always leaves the parser re-armed.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last) |=> (phase_r == PH_TYPE && err_r == ST_OK))
    else $error("parser not re-armed after final beat");

  // With an error latched, mid-payload beats leave the phase alone.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.last && err_r != ST_OK) |=>
      ($stable(phase_r) && $stable(err_r)))
    else $error("state moved after latched error");

  // The list counter never runs past the boolean.
  a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
    list_r <= 4'(NUM_LISTS))
    else $error("list index out of range");

  // Input is only held off by a pending output beat.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending output");

endmodule : kexinit_message_parser
`default_nettype wire

// ----- test/kexinit_message_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kexinit_message_parser_tb
// Self-checking bench for the key-exchange-init byte parser.
// ----------------------------------------------------------------------------
// Payloads are built as byte queues: mostly well-formed messages with random
// cookies, list lengths and contents, plus truncated, mistyped, nonzero
// reserved, overlong and pure-noise variants. A tracker inside the tag
// checker follows the parse, predicts each output beat and compares it with
// what the block returns. Both ends idle at random, and the expected type is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module kexinit_message_parser_tb
  import kexp_pkg::*;
();

  localparam int TB_COOKIE_LEN  = 16;
  localparam int NUM_NAME_LISTS = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 4;     // slack for the registered output beat to drain
  localparam int STUCK_LIMIT    = 3000;  // well above hold-off plus longest gaps
  localparam int REPORT_LIMIT   = 10;

  // --------------------------------------------------------------------------
  // Tag checker: tracks the parse and holds the tags still owed by the block
  // --------------------------------------------------------------------------
  class kexinit_tag_checker;
    logic [7:0]  exp_type;
    phase_t      phase;
    logic [4:0]  fcount;
    logic [3:0]  list_no;
    logic [31:0] len_acc;
    logic [31:0] remain;
    logic [7:0]  resv_or;
    logic [3:0]  err;
    logic        follows;
    kexp_out_t   pending_tags[$];
    int          mismatches;
    int          checked;

    function new();
      exp_type   = EXPECTED_TYPE_RST;
      mismatches = 0;
      checked    = 0;
      restart();
    endfunction

    function void restart();
      phase   = PH_TYPE;
      fcount  = '0;
      list_no = '0;
      len_acc = '0;
      remain  = '0;
      resv_or = '0;
      err     = ST_OK;
      follows = 1'b0;
    endfunction

    function void advance_list();
      list_no = list_no + 4'd1;
      fcount  = '0;
      len_acc = '0;
      phase   = (list_no >= NUM_NAME_LISTS) ? PH_BOOL : PH_LEN;
    endfunction

    function kexp_out_t tag_byte(kexp_in_t beat);
      kexp_out_t  t;
      logic [7:0] b;
      logic [3:0] st;
      b            = beat.data_byte;
      t.byte_class = CLS_IGNORED;
      t.list_index = '0;
      t.byte_out   = b;
      // once an error is latched the rest of the payload is ignored
      if (err == ST_OK) begin
        case (phase)
          PH_COOKIE: begin
            t.byte_class = CLS_COOKIE;
            fcount = fcount + 5'd1;
            if (fcount >= TB_COOKIE_LEN || fcount == 5'd0) begin
              list_no = '0;
              fcount  = '0;
              len_acc = '0;
              phase   = PH_LEN;
            end
          end
          PH_LEN: begin
            t.byte_class = CLS_LEN;
            t.list_index = list_no;
            len_acc = {len_acc[23:0], b};
            fcount  = fcount + 5'd1;
            if (fcount >= LEN_BYTES) begin
              fcount = '0;
              remain = len_acc;
              if (remain == 32'd0) advance_list();
              else phase = PH_LIST;
            end
          end
          PH_LIST: begin
            t.byte_class = CLS_LIST;
            t.list_index = list_no;
            remain = remain - 32'd1;
            if (remain == 32'd0) advance_list();
          end
          PH_BOOL: begin
            t.byte_class = CLS_BOOL;
            follows = (b != 8'd0);
            fcount  = '0;
            resv_or = '0;
            phase   = PH_RESV;
          end
          PH_RESV: begin
            t.byte_class = CLS_RESV;
            resv_or = resv_or | b;
            fcount  = fcount + 5'd1;
            if (fcount >= RESV_BYTES) begin
              fcount = '0;
              if (resv_or != 8'd0) err = ST_RESV_NONZERO;
              else phase = PH_END;
            end
          end
          PH_END: begin
            t.byte_class = CLS_IGNORED;
            err = ST_EXTRA_BYTES;
          end
          default: begin
            t.byte_class = CLS_TYPE;
            if (b != exp_type) begin
              err = ST_BAD_TYPE;
            end else begin
              fcount = '0;
              phase  = PH_COOKIE;
            end
          end
        endcase
      end
      // truncation is only judged on the closing byte
      st = err;
      if (beat.last && err == ST_OK) begin
        case (phase)
          PH_COOKIE: st = ST_TRUNC_COOKIE;
          PH_LEN:    st = ST_TRUNC_LEN;
          PH_LIST:   st = ST_TRUNC_LIST;
          PH_BOOL:   st = ST_TRUNC_BOOL;
          PH_RESV:   st = ST_TRUNC_RESV;
          PH_END:    st = ST_OK;
          default:   st = ST_TRUNC_COOKIE;
        endcase
      end
      t.status        = st;
      t.done_res      = beat.last;
      t.first_follows = follows;
      if (beat.last) restart();
      return t;
    endfunction

    function void note_byte(kexp_in_t beat);
      pending_tags.insert(pending_tags.size(), tag_byte(beat));
    endfunction

    function void check_tag(kexp_out_t got);
      kexp_out_t want;
      checked++;
      if (pending_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("output beat %0d arrived with nothing outstanding: %h", checked, got);
        return;
      end
      want = pending_tags.pop_front();
      if (got.byte_class !== want.byte_class || got.list_index !== want.list_index ||
          got.byte_out !== want.byte_out || got.status !== want.status ||
          got.done_res !== want.done_res || got.first_follows !== want.first_follows) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("output beat %0d expected: cls %0d idx %0d byte %h st %0d done %b fol %b",
                   checked, want.byte_class, want.list_index, want.byte_out, want.status,
                   want.done_res, want.first_follows);
          $display("output beat %0d got:      cls %0d idx %0d byte %h st %0d done %b fol %b",
                   checked, got.byte_class, got.list_index, got.byte_out, got.status,
                   got.done_res, got.first_follows);
        end
      end
    endfunction

    function int pending();
      return pending_tags.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  kexp_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  kexp_out_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kexinit_message_parser #(
    .COOKIE_LEN (TB_COOKIE_LEN),
    .NUM_LISTS  (NUM_NAME_LISTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kexinit_tag_checker tags = new();

  logic [7:0] payload[$];          // bytes of the payload being sent
  logic [7:0] cur_type = EXPECTED_TYPE_RST;
  bit         quiet    = 1'b0;     // set for stretches with no idling at all
  bit         hold_req = 1'b0;     // asks the receiver for one long hold-off
  int         beats_sent = 0;
  int         stuck_cycles = 0;

  // --------------------------------------------------------------------------
  // Beat monitors. Inputs are driven by NBA, so at the edge both sides still
  // show the values that were on the wires when the beat was taken. An input
  // beat's tag cannot come out at the same edge, so the order does not matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tags.note_byte(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tags.check_tag(out_data);
  end

  // Watchdog: only cycles in which neither side moves a beat are counted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("kexinit_message_parser_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and has to stall its input
  // --------------------------------------------------------------------------
  initial begin
    int n;
    wait (rst_n);
    forever begin
      n = idle_len();
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (quiet ? $urandom_range(8, 40) : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // valid stays high across back-to-back beats; it is only dropped for a gap
  task automatic send_beat(input logic [7:0] b, input logic lst);
    kexp_in_t beat;
    int       gap;
    beat.data_byte = b;
    beat.last      = lst;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stops until every owed tag is back, then lets the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tags.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_type(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tags.exp_type = v;
    cur_type      = v;
  endtask

  // Appends one byte to the payload under construction
  function automatic void append_byte(input logic [7:0] v);
    payload.insert(payload.size(), v);
  endfunction

  // Now and then pure noise; else a well-formed message, then perhaps one kind of damage
  function automatic void build_payload();
    int          kind;
    int          pick;
    int          cut;
    int          l;
    logic [31:0] len;
    int          len_pos[NUM_NAME_LISTS];
    payload.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      // pure noise, may or may not start with a good type byte
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
      return;
    end
    append_byte(cur_type);
    repeat (TB_COOKIE_LEN) append_byte(8'($urandom));
    for (int i = 0; i < NUM_NAME_LISTS; i++) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 5) ? 32'd0 : (pick < 9) ? 32'($urandom_range(1, 3))
                                            : 32'($urandom_range(4, 12));
      len_pos[i] = payload.size();
      for (int k = 3; k >= 0; k--) append_byte(len[8*k +: 8]);
      repeat (len) append_byte(8'($urandom));
    end
    pick = $urandom_range(0, 9);
    append_byte((pick < 5) ? 8'h00 : (pick < 8) ? 8'h01 : 8'($urandom));
    repeat (RESV_BYTES) append_byte(8'h00);

    if (kind < 55) begin
      // left intact
    end else if (kind < 65) begin
      cut = $urandom_range(1, payload.size() - 1);
      while (payload.size() > cut) void'(payload.pop_back());
    end else if (kind < 73) begin
      payload[0] = cur_type ^ 8'($urandom_range(1, 255));
    end else if (kind < 81) begin
      // nonzero reserved, sometimes cut inside the reserved field
      payload[payload.size() - 1 - $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) void'(payload.pop_back());
    end else if (kind < 89) begin
      repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
    end else begin
      // huge declared length, payload ends a few list bytes in
      l = $urandom_range(0, NUM_NAME_LISTS - 1);
      payload[len_pos[l]] = 8'($urandom_range(1, 255));
      for (int k = 1; k < 4; k++) payload[len_pos[l] + k] = 8'($urandom);
      cut = len_pos[l] + 4 + $urandom_range(0, 4);
      while (payload.size() > cut) void'(payload.pop_back());
    end
  endfunction

  task automatic send_payload();
    for (int i = 0; i < payload.size(); i++)
      send_beat(payload[i], i == payload.size() - 1);
  endtask

  task automatic run_phase(input logic [7:0] type_val, input int beats, input bit with_hold);
    int start;
    bit held;
    held = 1'b0;
    wait_idle();
    write_type(type_val);
    start = beats_sent;
    while (beats_sent - start < beats) begin
      if (with_hold && !held && beats_sent - start > beats / 3) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      quiet = ($urandom_range(0, 5) == 0);
      build_payload();
      send_payload();
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset type: lone type byte, lone bad type, error then
    // ignored byte, cookie cut short with the extreme byte values
    send_beat(EXPECTED_TYPE_RST, 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h5A, 1'b1);
    send_beat(EXPECTED_TYPE_RST, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b1);

    // directed, top type value
    wait_idle();
    write_type(8'hFF);
    send_beat(8'hFF, 1'b1);
    send_beat(EXPECTED_TYPE_RST, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7E, 1'b1);

    // random phases over several type settings
    run_phase(8'h00, 440, 1'b1);
    run_phase(8'($urandom), 440, 1'b0);
    run_phase(8'hFF, 440, 1'b0);
    run_phase(EXPECTED_TYPE_RST, 430, 1'b0);

    wait_idle();
    if (tags.mismatches == 0 && tags.pending() == 0) begin
      $display("kexinit_message_parser_tb: PASS");
    end else begin
      $display("kexinit_message_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kexp_pkg.sv
hw/rtl/kexinit_message_parser.sv
test/kexinit_message_parser_tb.sv
